// ----- hdl/pdf_literal_string_unescape_macros.svh -----
// Assertion macros shared by the literal string decoder files
`ifndef PDF_LITERAL_STRING_UNESCAPE_MACROS_SVH
`define PDF_LITERAL_STRING_UNESCAPE_MACROS_SVH

// Same-cycle implication, checked outside reset
`define PLS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset
`define PLS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/pls_pkg.sv -----
// ----------------------------------------------------------------------------
// pls_pkg
// Shared types, character codes and mode codes of the literal string decoder.
// ----------------------------------------------------------------------------
package pls_pkg;

	localparam int DEPTH_BITS = 8;

	// decoder mode codes
	localparam logic [2:0] MODE_PLAIN  = 3'd0;
	localparam logic [2:0] MODE_ESC    = 3'd1;
	localparam logic [2:0] MODE_ESC_CR = 3'd2;
	localparam logic [2:0] MODE_CR     = 3'd3;
	localparam logic [2:0] MODE_OCT    = 3'd4;

	// character codes
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_BS     = 8'h08;
	localparam logic [7:0] CH_FF     = 8'h0C;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_B      = 8'h62;
	localparam logic [7:0] CH_F      = 8'h66;

	localparam logic [1:0] OCT_MAX_DIGITS = 2'd3;

	typedef struct packed {
		logic [7:0] data;
		logic       byte_ok;
		logic       done;
		logic       last;
	} res_t;

	// results of one decoded byte
	typedef struct packed {
		logic [1:0] cnt;
		res_t       r0;
		res_t       r1;
	} dec_out_t;

endpackage

// ----- hdl/pls_decode.sv -----
// ----------------------------------------------------------------------------
// pls_decode
// Escape, octal, CR-LF and nesting decode of one byte; holds the decode state.
// ----------------------------------------------------------------------------
`include "pdf_literal_string_unescape_macros.svh"

module pls_decode (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 commit,
	input  logic [7:0]           data_in,
	output pls_pkg::dec_out_t    dec
);

	typedef struct packed {
		logic                          emit;
		pls_pkg::res_t                 r;
		logic [2:0]                    mode;
		logic [pls_pkg::DEPTH_BITS-1:0] depth;
		logic                          clr;
	} plain_t;

	localparam logic [1:0] OCT_LIMIT = pls_pkg::OCT_MAX_DIGITS;

	logic [2:0]                     mode_q, mode_d;
	logic [7:0]                     oct_val_q, oct_val_d;
	logic [1:0]                     oct_cnt_q, oct_cnt_d;
	logic [pls_pkg::DEPTH_BITS-1:0] depth_q, depth_d;

	plain_t        p;
	logic          use_plain;
	logic          pre_emit;
	logic [7:0]    pre_data;
	logic          is_oct;
	logic [7:0]    oct_nxt;
	logic [1:0]    cnt;
	pls_pkg::res_t r0, r1;

	function automatic pls_pkg::res_t mk(input logic [7:0] d);
		pls_pkg::res_t r;
		r.data    = d;
		r.byte_ok = 1'b1;
		r.done    = 1'b0;
		r.last    = 1'b0;
		return r;
	endfunction

	function automatic plain_t plain_step(input logic [7:0] b,
			input logic [pls_pkg::DEPTH_BITS-1:0] d);
		plain_t o;
		o.emit  = 1'b0;
		o.r     = mk(b);
		o.mode  = pls_pkg::MODE_PLAIN;
		o.depth = d;
		o.clr   = 1'b0;
		if (b == pls_pkg::CH_BSLASH) begin
			o.mode = pls_pkg::MODE_ESC;
		end else if (b == pls_pkg::CH_CR) begin
			o.mode = pls_pkg::MODE_CR;
		end else if (b == pls_pkg::CH_LPAREN) begin
			o.emit = 1'b1;
			if (d != '1)
				o.depth = d + 1'b1;
		end else if (b == pls_pkg::CH_RPAREN) begin
			o.emit = 1'b1;
			if (d == '0) begin
				// close of the string: marker word, no data
				o.r.data    = 8'h00;
				o.r.byte_ok = 1'b0;
				o.r.done    = 1'b1;
				o.clr       = 1'b1;
			end else begin
				o.depth = d - 1'b1;
			end
		end else begin
			o.emit = 1'b1;
		end
		return o;
	endfunction

	assign is_oct  = (data_in[7:3] == pls_pkg::CH_ZERO[7:3]);
	assign oct_nxt = {oct_val_q[4:0], data_in[2:0]};
	assign p       = plain_step(data_in, depth_q);

	always_comb begin
		mode_d    = pls_pkg::MODE_PLAIN;
		oct_val_d = oct_val_q;
		oct_cnt_d = oct_cnt_q;
		depth_d   = depth_q;
		use_plain = 1'b0;
		pre_emit  = 1'b0;
		pre_data  = 8'h00;
		cnt       = 2'd0;
		r0        = p.r;
		r1        = p.r;
		unique case (mode_q)
			pls_pkg::MODE_ESC: begin
				case (data_in) inside
					pls_pkg::CH_N: begin r0 = mk(pls_pkg::CH_LF); cnt = 2'd1; end
					pls_pkg::CH_R: begin r0 = mk(pls_pkg::CH_CR); cnt = 2'd1; end
					pls_pkg::CH_T: begin r0 = mk(pls_pkg::CH_TAB); cnt = 2'd1; end
					pls_pkg::CH_B: begin r0 = mk(pls_pkg::CH_BS); cnt = 2'd1; end
					pls_pkg::CH_F: begin r0 = mk(pls_pkg::CH_FF); cnt = 2'd1; end
					pls_pkg::CH_LPAREN, pls_pkg::CH_RPAREN, pls_pkg::CH_BSLASH: begin
						r0  = mk(data_in);
						cnt = 2'd1;
					end
					pls_pkg::CH_LF: begin
						cnt = 2'd0;
					end
					pls_pkg::CH_CR: begin
						mode_d = pls_pkg::MODE_ESC_CR;
					end
					default: begin
						if (is_oct) begin
							oct_val_d = {5'd0, data_in[2:0]};
							oct_cnt_d = 2'd1;
							mode_d    = pls_pkg::MODE_OCT;
						end else begin
							// unknown escape: keep the backslash
							pre_emit  = 1'b1;
							pre_data  = pls_pkg::CH_BSLASH;
							use_plain = 1'b1;
						end
					end
				endcase
			end
			pls_pkg::MODE_ESC_CR: begin
				use_plain = (data_in != pls_pkg::CH_LF);
			end
			pls_pkg::MODE_CR: begin
				if (data_in == pls_pkg::CH_LF) begin
					r0  = mk(pls_pkg::CH_LF);
					cnt = 2'd1;
				end else begin
					pre_emit  = 1'b1;
					pre_data  = pls_pkg::CH_CR;
					use_plain = 1'b1;
				end
			end
			pls_pkg::MODE_OCT: begin
				if (is_oct && (oct_cnt_q < OCT_LIMIT)) begin
					if (oct_cnt_q == OCT_LIMIT - 2'd1) begin
						r0        = mk(oct_nxt);
						cnt       = 2'd1;
						oct_val_d = 8'h00;
						oct_cnt_d = 2'd0;
					end else begin
						oct_val_d = oct_nxt;
						oct_cnt_d = oct_cnt_q + 2'd1;
						mode_d    = pls_pkg::MODE_OCT;
					end
				end else begin
					// octal run ended early: flush it, then take the byte as text
					pre_emit  = 1'b1;
					pre_data  = oct_val_q;
					oct_val_d = 8'h00;
					oct_cnt_d = 2'd0;
					use_plain = 1'b1;
				end
			end
			default: begin
				use_plain = 1'b1;
			end
		endcase

		if (use_plain) begin
			mode_d  = p.mode;
			depth_d = p.depth;
			if (p.clr) begin
				oct_val_d = 8'h00;
				oct_cnt_d = 2'd0;
			end
			if (pre_emit) begin
				r0  = mk(pre_data);
				r1  = p.r;
				cnt = p.emit ? 2'd2 : 2'd1;
			end else begin
				r0  = p.r;
				cnt = p.emit ? 2'd1 : 2'd0;
			end
		end

		r0.last = (cnt == 2'd1);
		r1.last = 1'b1;
	end

	assign dec.cnt = cnt;
	assign dec.r0  = r0;
	assign dec.r1  = r1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= pls_pkg::MODE_PLAIN;
			oct_val_q <= 8'h00;
			oct_cnt_q <= 2'd0;
			depth_q   <= '0;
		end else if (commit) begin
			mode_q    <= mode_d;
			oct_val_q <= oct_val_d;
			oct_cnt_q <= oct_cnt_d;
			depth_q   <= depth_d;
		end
	end

	`PLS_ASSERT_IMP(a_oct_cnt_live, clk, arst_n, mode_q == pls_pkg::MODE_OCT,
		(oct_cnt_q == 2'd1) || (oct_cnt_q == 2'd2), "octal mode without a digit count")
	`PLS_ASSERT_IMP(a_done_alone, clk, arst_n, commit && dec.r0.done,
		(dec.cnt != 2'd0) && !dec.r0.byte_ok, "string end word carries data")

endmodule

// ----- hdl/pls_out_buf.sv -----
// ----------------------------------------------------------------------------
// pls_out_buf
// Two-slot result buffer: slot 0 drives the output, slot 1 holds a second word.
// ----------------------------------------------------------------------------
`include "pdf_literal_string_unescape_macros.svh"

module pls_out_buf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  pls_pkg::dec_out_t dec,
	output logic              room,
	output logic              out_valid,
	input  logic              out_stall,
	output pls_pkg::res_t     head
);

	logic          v0_q, v1_q;
	pls_pkg::res_t slot0_q, slot1_q;
	logic          free0;

	// slot 0 frees when it is empty or its word leaves this cycle
	assign free0     = !v0_q || !out_stall;
	assign room      = !v1_q && free0;
	assign out_valid = v0_q;
	assign head      = slot0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v0_q <= 1'b0;
			v1_q <= 1'b0;
		end else if (free0) begin
			if (v1_q) begin
				v0_q <= 1'b1;
				v1_q <= 1'b0;
			end else if (push) begin
				v0_q <= (dec.cnt != 2'd0);
				v1_q <= (dec.cnt == 2'd2);
			end else begin
				v0_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (free0) begin
			if (v1_q)
				slot0_q <= slot1_q;
			else if (push)
				slot0_q <= dec.r0;
			if (push)
				slot1_q <= dec.r1;
		end
	end

	`PLS_ASSERT_IMP(a_push_room, clk, arst_n, push, room, "result pushed with no room")
	`PLS_ASSERT_IMP(a_slot_order, clk, arst_n, v1_q, v0_q, "second slot full ahead of the first")
	`PLS_ASSERT_NXT(a_hold_stalled, clk, arst_n, v0_q && out_stall, v0_q && $stable(slot0_q), "stalled head word changed")

endmodule

// ----- hdl/pdf_literal_string_unescape.sv -----
// ----------------------------------------------------------------------------
// pdf_literal_string_unescape
// Decodes the body bytes of a literal string into unescaped data words.
// ----------------------------------------------------------------------------
//  channel | ports                                                       | dir
//  --------+-------------------------------------------------------------+-----
//  in      | in_valid, in_stall, in_byte                                 | in
//  out     | out_valid, out_stall, out_byte, byte_valid, string_done, last | out
//
// One input byte per cycle while the output is not stalled; a byte that
// yields two words holds the input while the second word drains through
// the output port. A byte enters the input register, is decoded against
// the mode state and lands in a two-slot result buffer.
// Reset clears the mode, octal and nesting state and empties both stages.
// Output stall holds the head word and back-pressures the input register.
// ----------------------------------------------------------------------------
`include "pdf_literal_string_unescape_macros.svh"

module pdf_literal_string_unescape (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       byte_valid,
	output logic       string_done,
	output logic       last
);

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              room;
	logic              advance;
	pls_pkg::dec_out_t dec;
	pls_pkg::res_t     head;

	assign advance  = valid_s1 && room;
	assign in_stall = valid_s1 && !room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (!in_stall)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid)
			byte_s1 <= in_byte;
	end

	pls_decode u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.commit  (advance),
		.data_in (byte_s1),
		.dec     (dec)
	);

	pls_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (advance),
		.dec       (dec),
		.room      (room),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.head      (head)
	);

	assign out_byte    = head.data;
	assign byte_valid  = head.byte_ok;
	assign string_done = head.done;
	assign last        = head.last;

	`PLS_ASSERT_IMP(a_stall_cause, clk, arst_n, in_stall, valid_s1 && (out_valid || !room), "input stalled with nothing ahead")

endmodule

// ----- test/tb_pdf_literal_string_unescape.sv -----
// ----------------------------------------------------------------------------
// tb_pdf_literal_string_unescape
// Self-checking bench for the literal string body decoder. A queue of raw
// bytes (directed escapes, octal runs, line breaks, deep nesting, then random
// mixes of these with noise bytes) feeds a driver. A monitor decodes each
// accepted byte with a local model of the decoder and compares every output
// word, field by field, against the oldest expected word.
// ----------------------------------------------------------------------------
module tb_pdf_literal_string_unescape;

	localparam int N_ITEMS   = 1450;
	localparam int CYC_LIMIT = 200000;
	localparam int HOLD_AT   = 300;
	localparam int HOLD_LEN  = 300;
	localparam int PAUSE_AT  = 1100;
	localparam int PHASE1_AT = 480;
	localparam int PHASE2_AT = 960;
	localparam int MAX_SHOWN = 10;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] in_byte;
	logic       out_valid;
	logic       out_stall;
	logic [7:0] out_byte;
	logic       byte_valid;
	logic       string_done;
	logic       last;

	logic [7:0]    pend_bytes[$];
	pls_pkg::res_t exp_words[$];

	// decoder model state
	logic [2:0]                     dec_mode;
	logic [7:0]                     oct_acc;
	logic [1:0]                     oct_cnt;
	logic [pls_pkg::DEPTH_BITS-1:0] paren_depth;

	bit in_fire;
	int taken_cnt;
	int sent_cnt;
	int fail_cnt;
	int cycles;
	int hold_left;
	bit hold_done;

	pdf_literal_string_unescape dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_byte    (in_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.byte_valid (byte_valid),
		.string_done(string_done),
		.last       (last)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic bit is_octal(logic [7:0] b);
		return (b >= pls_pkg::CH_ZERO) && (b <= pls_pkg::CH_ZERO + 8'd7);
	endfunction

	function automatic void push_word(logic [7:0] d, logic ok, logic dn);
		pls_pkg::res_t w;
		w.data    = d;
		w.byte_ok = ok;
		w.done    = dn;
		w.last    = 1'b0;
		exp_words.push_back(w);
	endfunction

	function automatic void decode_plain(logic [7:0] b);
		dec_mode = pls_pkg::MODE_PLAIN;
		if (b == pls_pkg::CH_BSLASH) begin
			dec_mode = pls_pkg::MODE_ESC;
		end else if (b == pls_pkg::CH_CR) begin
			dec_mode = pls_pkg::MODE_CR;
		end else if (b == pls_pkg::CH_LPAREN) begin
			if (paren_depth != '1)
				paren_depth = paren_depth + 1'b1;
			push_word(b, 1'b1, 1'b0);
		end else if (b == pls_pkg::CH_RPAREN) begin
			if (paren_depth == '0) begin
				// closing paren at top level: end of string
				oct_acc = '0;
				oct_cnt = '0;
				push_word(8'h00, 1'b0, 1'b1);
			end else begin
				paren_depth = paren_depth - 1'b1;
				push_word(b, 1'b1, 1'b0);
			end
		end else begin
			push_word(b, 1'b1, 1'b0);
		end
	endfunction

	function automatic void decode_escape(logic [7:0] b);
		dec_mode = pls_pkg::MODE_PLAIN;
		case (b)
			pls_pkg::CH_N: push_word(pls_pkg::CH_LF, 1'b1, 1'b0);
			pls_pkg::CH_R: push_word(pls_pkg::CH_CR, 1'b1, 1'b0);
			pls_pkg::CH_T: push_word(pls_pkg::CH_TAB, 1'b1, 1'b0);
			pls_pkg::CH_B: push_word(pls_pkg::CH_BS, 1'b1, 1'b0);
			pls_pkg::CH_F: push_word(pls_pkg::CH_FF, 1'b1, 1'b0);
			pls_pkg::CH_LPAREN, pls_pkg::CH_RPAREN, pls_pkg::CH_BSLASH:
				push_word(b, 1'b1, 1'b0);
			pls_pkg::CH_LF: ;
			pls_pkg::CH_CR: dec_mode = pls_pkg::MODE_ESC_CR;
			default: begin
				if (is_octal(b)) begin
					oct_acc  = b - pls_pkg::CH_ZERO;
					oct_cnt  = 2'd1;
					dec_mode = pls_pkg::MODE_OCT;
				end else begin
					// unknown escape keeps its backslash
					push_word(pls_pkg::CH_BSLASH, 1'b1, 1'b0);
					decode_plain(b);
				end
			end
		endcase
	endfunction

	function automatic void decode_byte(logic [7:0] b);
		int            n0;
		pls_pkg::res_t w;
		n0 = exp_words.size();
		case (dec_mode)
			pls_pkg::MODE_ESC: decode_escape(b);
			pls_pkg::MODE_ESC_CR: begin
				dec_mode = pls_pkg::MODE_PLAIN;
				if (b != pls_pkg::CH_LF)
					decode_plain(b);
			end
			pls_pkg::MODE_CR: begin
				dec_mode = pls_pkg::MODE_PLAIN;
				if (b == pls_pkg::CH_LF) begin
					push_word(pls_pkg::CH_LF, 1'b1, 1'b0);
				end else begin
					push_word(pls_pkg::CH_CR, 1'b1, 1'b0);
					decode_plain(b);
				end
			end
			pls_pkg::MODE_OCT: begin
				if (is_octal(b) && oct_cnt < pls_pkg::OCT_MAX_DIGITS) begin
					oct_acc = (oct_acc << 3) + (b - pls_pkg::CH_ZERO);
					oct_cnt = oct_cnt + 1'b1;
					if (oct_cnt == pls_pkg::OCT_MAX_DIGITS) begin
						push_word(oct_acc, 1'b1, 1'b0);
						oct_acc  = '0;
						oct_cnt  = '0;
						dec_mode = pls_pkg::MODE_PLAIN;
					end
				end else begin
					push_word(oct_acc, 1'b1, 1'b0);
					oct_acc = '0;
					oct_cnt = '0;
					decode_plain(b);
				end
			end
			default: decode_plain(b);
		endcase
		// flag the final word of this byte
		if (exp_words.size() > n0) begin
			w = exp_words.pop_back();
			w.last = 1'b1;
			exp_words.push_back(w);
		end
	endfunction

	function automatic logic [7:0] pick_escape(int k);
		case (k)
			0: return pls_pkg::CH_N;
			1: return pls_pkg::CH_R;
			2: return pls_pkg::CH_T;
			3: return pls_pkg::CH_B;
			4: return pls_pkg::CH_F;
			5: return pls_pkg::CH_LPAREN;
			6: return pls_pkg::CH_RPAREN;
			default: return pls_pkg::CH_BSLASH;
		endcase
	endfunction

	function automatic void queue_str(string s);
		for (int i = 0; i < s.len(); i++)
			pend_bytes.push_back(s[i]);
	endfunction

	// Fill the stimulus queue: directed part, deep nesting, then random strings
	function automatic void build_stimulus();
		int k;
		int nd;
		pend_bytes.push_back(pls_pkg::CH_LPAREN);
		pend_bytes.push_back(8'h00);
		pend_bytes.push_back(8'hFF);
		queue_str("\\n\\t\\f");
		pend_bytes.push_back(pls_pkg::CH_BSLASH); pend_bytes.push_back(pls_pkg::CH_LF);
		pend_bytes.push_back(pls_pkg::CH_BSLASH); pend_bytes.push_back(pls_pkg::CH_CR);
		pend_bytes.push_back(pls_pkg::CH_LF);
		pend_bytes.push_back(pls_pkg::CH_BSLASH); pend_bytes.push_back(pls_pkg::CH_CR);
		queue_str("A\\101\\7x\\777");
		pend_bytes.push_back(pls_pkg::CH_CR); pend_bytes.push_back(pls_pkg::CH_LF);
		pend_bytes.push_back(pls_pkg::CH_CR);
		queue_str("Z\\q))");
		// saturate the nesting counter, then unwind past it to close
		for (int i = 0; i < 257; i++)
			pend_bytes.push_back(pls_pkg::CH_LPAREN);
		for (int i = 0; i < 256; i++)
			pend_bytes.push_back(pls_pkg::CH_RPAREN);
		while (pend_bytes.size() < N_ITEMS) begin
			k = $urandom_range(0, 99);
			if (k < 20) begin
				pend_bytes.push_back(8'($urandom_range(0, 255)));
			end else if (k < 40) begin
				pend_bytes.push_back(8'($urandom_range(8'h20, 8'h7E)));
			end else if (k < 52) begin
				pend_bytes.push_back(pls_pkg::CH_BSLASH);
				pend_bytes.push_back(pick_escape($urandom_range(0, 7)));
			end else if (k < 62) begin
				nd = $urandom_range(1, 3);
				pend_bytes.push_back(pls_pkg::CH_BSLASH);
				for (int i = 0; i < nd; i++)
					pend_bytes.push_back(pls_pkg::CH_ZERO + 8'($urandom_range(0, 7)));
			end else if (k < 66) begin
				pend_bytes.push_back(pls_pkg::CH_CR);
				pend_bytes.push_back(pls_pkg::CH_LF);
			end else if (k < 68) begin
				pend_bytes.push_back(pls_pkg::CH_CR);
			end else if (k < 71) begin
				pend_bytes.push_back(pls_pkg::CH_BSLASH);
				pend_bytes.push_back(pls_pkg::CH_CR);
				pend_bytes.push_back(pls_pkg::CH_LF);
			end else if (k < 72) begin
				pend_bytes.push_back(pls_pkg::CH_BSLASH);
				pend_bytes.push_back(pls_pkg::CH_CR);
			end else if (k < 74) begin
				pend_bytes.push_back(pls_pkg::CH_BSLASH);
				pend_bytes.push_back(pls_pkg::CH_LF);
			end else if (k < 77) begin
				pend_bytes.push_back(pls_pkg::CH_BSLASH);
				pend_bytes.push_back(8'($urandom_range(0, 255)));
			end else if (k < 87) begin
				pend_bytes.push_back(pls_pkg::CH_LPAREN);
			end else begin
				pend_bytes.push_back(pls_pkg::CH_RPAREN);
			end
		end
	endfunction

	task automatic note_fail(string msg);
		fail_cnt++;
		if (fail_cnt <= MAX_SHOWN)
			$display("%s", msg);
	endtask

	// Monitor: accept input bytes into the model, check output words
	always @(posedge clk) begin
		pls_pkg::res_t w;
		if (arst_n) begin
			in_fire = in_valid && !in_stall;
			if (in_fire) begin
				decode_byte(in_byte);
				taken_cnt++;
			end
			if (out_valid && !out_stall) begin
				if (exp_words.size() == 0) begin
					note_fail($sformatf("unexpected word: byte %h valid %b done %b last %b",
						out_byte, byte_valid, string_done, last));
				end else begin
					w = exp_words.pop_front();
					if (out_byte !== w.data || byte_valid !== w.byte_ok ||
						string_done !== w.done || last !== w.last)
						note_fail($sformatf(
							"mismatch: exp byte %h valid %b done %b last %b, got %h %b %b %b",
							w.data, w.byte_ok, w.done, w.last,
							out_byte, byte_valid, string_done, last));
				end
			end
		end
	end

	// Sender
	always @(negedge clk) begin
		int idle_pct;
		if (arst_n) begin
			idle_pct = (taken_cnt < PHASE1_AT) ? 12 : (taken_cnt < PHASE2_AT) ? 51 : 0;
			if (!in_valid || in_fire) begin
				// hold at the pause point until every expected word has drained
				if (pend_bytes.size() == 0 || $urandom_range(0, 99) < idle_pct ||
					(sent_cnt == PAUSE_AT && exp_words.size() != 0)) begin
					in_valid <= 1'b0;
				end else begin
					in_byte  <= pend_bytes.pop_front();
					in_valid <= 1'b1;
					sent_cnt++;
				end
			end
		end
	end

	// Receiver, with one long hold-off to back the block up
	always @(negedge clk) begin
		int stall_pct;
		if (arst_n) begin
			stall_pct = (taken_cnt < PHASE1_AT) ? 51 : (taken_cnt < PHASE2_AT) ? 12 : 0;
			if (!hold_done && taken_cnt >= HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = HOLD_LEN;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(0, 99) < stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYC_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		in_byte     = 8'h00;
		out_stall   = 1'b0;
		in_fire     = 1'b0;
		dec_mode    = pls_pkg::MODE_PLAIN;
		oct_acc     = '0;
		oct_cnt     = '0;
		paren_depth = '0;
		build_stimulus();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		while (pend_bytes.size() != 0 || in_valid)
			@(negedge clk);
		while (exp_words.size() != 0)
			@(negedge clk);
		// allow any stray word to surface
		repeat (10) @(negedge clk);
		if (fail_cnt == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
